@@ hdl/bistable_network_euler_step_unit_macros.svh @@
// ----------------------------------------------------------------------------
// bistable network euler step unit assertion macros
// concurrent check wrappers clocked on clk_i, switchable as a group
// ----------------------------------------------------------------------------
`ifndef BISTABLE_NETWORK_EULER_STEP_UNIT_MACROS_SVH
`define BISTABLE_NETWORK_EULER_STEP_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset only
`define BNES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define BNES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BNES_ASSERT(lbl, prop, msg)
`define BNES_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/bnes_pkg.sv @@
// ----------------------------------------------------------------------------
// bnes_pkg
// shared codes, reset values and helpers of the euler step unit
// ----------------------------------------------------------------------------
package bnes_pkg;

  localparam int FRAC  = 24;
  localparam int ACC_W = 44;

  // request operations
  localparam logic [2:0] OP_WR_STATE = 3'd0;
  localparam logic [2:0] OP_WR_DEG   = 3'd1;
  localparam logic [2:0] OP_WR_NB    = 3'd2;
  localparam logic [2:0] OP_STEP     = 3'd3;
  localparam logic [2:0] OP_RD_STATE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_NODE_COUNT = 3'd0;
  localparam logic [2:0] CFG_COUPLING   = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP  = 3'd2;
  localparam logic [2:0] CFG_DAMPING    = 3'd3;
  localparam logic [2:0] CFG_GAIN       = 3'd4;
  localparam logic [2:0] CFG_UPPER_KNEE = 3'd5;
  localparam logic [2:0] CFG_LOWER_KNEE = 3'd6;

  // reset values
  localparam logic [6:0]         RST_NODE_COUNT = 7'd64;
  localparam logic signed [31:0] RST_COUPLING   = 32'sd0;
  localparam logic [30:0]        RST_TIME_STEP  = 31'd167772;
  localparam logic signed [31:0] RST_DAMPING    = 32'sd30198989;
  localparam logic signed [31:0] RST_GAIN       = 32'sd50331648;
  localparam logic signed [31:0] RST_UPPER_KNEE = 32'sd16777216;
  localparam logic signed [31:0] RST_LOWER_KNEE = -32'sd16777216;

  // sync well codes
  localparam logic [1:0] SYNC_NONE = 2'd0;
  localparam logic [1:0] SYNC_POS  = 2'd1;
  localparam logic [1:0] SYNC_NEG  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } bnes_div_st_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ hdl/bnes_div.sv @@
// ----------------------------------------------------------------------------
// bnes_div
// restoring divider, one quotient bit a cycle, truncates toward zero
// ----------------------------------------------------------------------------
module bnes_div import bnes_pkg::*; #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output bnes_div_st_t            status_o,
  output logic signed [NUM_W-1:0] quot_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] mag_q;
  logic [DEN_W:0]   rem_q;
  logic [DEN_W-1:0] den_q;
  logic signed [NUM_W-1:0] quot_q;

  logic [DEN_W:0]   shifted, trial;
  logic             fits;
  logic [NUM_W-1:0] mag_next;

  always_comb begin
    shifted  = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
    trial    = shifted - {1'b0, den_q};
    fits     = shifted >= {1'b0, den_q};
    mag_next = {mag_q[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NUM_W-1];
      mag_q <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      mag_q <= mag_next;
      rem_q <= fits ? trial : shifted;
      if (cnt_q == CW'(1)) begin
        quot_q <= neg_q ? -$signed(mag_next) : $signed(mag_next);
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

@@ hdl/bistable_network_euler_step_unit.sv @@
// ----------------------------------------------------------------------------
// bistable_network_euler_step_unit
// node store, neighbor table and a sequenced euler step over the network
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid_i / in_stall_o) takes one request: op, node,
//    slot, value; output channel (out_valid_o / out_stall_i) returns one
//    result per request: read_value, sync_well, bad_request
//  - config writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at once
//  - writes and bad requests: result in the cycle after the request
//  - state read: result through S_READ (memory read), then the output register
//  - step: per active node a rate pass of P_RD, P_X, P_M1, P_M2 and P_WR plus,
//    for degree > 0, P_NB, P_NA, P_NS per neighbor, then P_DIV, P_DW for the
//    mean divide (one bit a cycle in bnes_div) and P_M3; then an update pass
//    of Q_RD, Q_MUL, Q_ADD per node, paced by the shared multiplier and divider
//  - one request at a time: in_stall_o is high while a request is in work
//    and while an unread result is held with out_stall_i high
//  - reset: a clearing pass over 2**(NODE_W + SLOT_W) addresses (512 by default)
//    zeroes states, degrees and neighbors; no request is taken meanwhile
//  - a stalled result holds in the output register
// ----------------------------------------------------------------------------
`include "bistable_network_euler_step_unit_macros.svh"

module bistable_network_euler_step_unit import bnes_pkg::*; #(
  parameter int MAX_NODES  = 64,
  parameter int MAX_DEGREE = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         op_i,
  input  logic [5:0]         node_i,
  input  logic [2:0]         slot_i,
  input  logic signed [31:0] value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         sync_well_o,
  output logic               bad_request_o,
  // config port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int SLOT_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int TAB_AW = NODE_W + SLOT_W;
  localparam int SUM_W  = 32 + $clog2(MAX_DEGREE) + 1;

  // sequencer codes
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_READ  = 5'd2;
  localparam logic [4:0] P_RD    = 5'd3;
  localparam logic [4:0] P_X     = 5'd4;
  localparam logic [4:0] P_M1    = 5'd5;
  localparam logic [4:0] P_M2    = 5'd6;
  localparam logic [4:0] P_NB    = 5'd7;
  localparam logic [4:0] P_NA    = 5'd8;
  localparam logic [4:0] P_NS    = 5'd9;
  localparam logic [4:0] P_DIV   = 5'd10;
  localparam logic [4:0] P_DW    = 5'd11;
  localparam logic [4:0] P_M3    = 5'd12;
  localparam logic [4:0] P_WR    = 5'd13;
  localparam logic [4:0] Q_RD    = 5'd14;
  localparam logic [4:0] Q_MUL   = 5'd15;
  localparam logic [4:0] Q_ADD   = 5'd16;

  // config registers
  logic [6:0]         node_count_q;
  logic signed [31:0] coupling_q, damping_q, gain_q, upper_q, lower_q;
  logic [30:0]        time_step_q;

  // memories
  logic signed [31:0] state_mem [MAX_NODES];
  logic signed [31:0] rate_mem  [MAX_NODES];
  logic [DEG_W-1:0]   deg_mem   [MAX_NODES];
  logic [NODE_W-1:0]  nb_mem    [MAX_NODES << SLOT_W];

  logic signed [31:0] st_rdata_q, rate_rdata_q;
  logic [DEG_W-1:0]   deg_rdata_q;
  logic [NODE_W-1:0]  nb_rdata_q;

  logic               st_we, rate_we, deg_we, nb_we;
  logic [NODE_W-1:0]  st_waddr, st_raddr, deg_waddr;
  logic [TAB_AW-1:0]  nb_waddr, nb_raddr;
  logic signed [31:0] st_wdata;
  logic [DEG_W-1:0]   deg_wdata;
  logic [NODE_W-1:0]  nb_wdata;

  // sequencer state
  logic [4:0]          state_q, state_d;
  logic [TAB_AW-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]    i_q, i_d, n_eff;
  logic [DEG_W-1:0]    k_q, k_d, deg_q, deg_d;
  logic signed [31:0]  x_q, x_d, first_q, first_d;
  logic                pos_q, pos_d, neg_q, neg_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [NODE_W-1:0]   i_idx;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [64:0] prod_q;
  logic signed [ACC_W-1:0] prod_sh;

  // divider
  logic               div_start;
  bnes_div_st_t       div_st;
  logic signed [SUM_W-1:0] quot;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] rd_q, rd_d;
  logic [1:0]         sync_q, sync_d;
  logic               bad_q, bad_d;

  logic               accept, out_take, node_oob, last_node;
  logic signed [31:0] cl, d_val, nx;
  logic signed [SUM_W:0] diff;
  logic               first_f, pos_f, neg_f;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign node_oob = {26'd0, node_i} >= 32'(MAX_NODES);
  assign i_idx    = NODE_W'(i_q);
  assign last_node = (i_q == CNT_W'(n_eff - 1'b1));
  assign prod_sh  = ACC_W'(prod_q >>> FRAC);

  // active node count, zero acts as one, above MAX_NODES acts as MAX_NODES
  always_comb begin
    if (node_count_q == '0) n_eff = CNT_W'(1);
    else if (32'(node_count_q) > 32'(MAX_NODES)) n_eff = CNT_W'(MAX_NODES);
    else n_eff = CNT_W'(node_count_q);
  end

  // clamp of the old state to the knees
  always_comb begin
    if (x_q < lower_q) cl = lower_q;
    else if (x_q <= upper_q) cl = x_q;
    else cl = upper_q;
  end

  // coupling difference, mean minus own state
  assign diff  = (SUM_W + 1)'(quot) - (SUM_W + 1)'(x_q);
  assign d_val = sat32(64'(diff));

  // updated state and sync flags for the update pass
  assign nx      = sat32(64'(x_q) + 64'(prod_sh));
  assign first_f = 1'b0;
  always_comb begin
    pos_f = pos_q || ((i_q != '0) && (nx > 0));
    neg_f = neg_q || ((i_q != '0) && (nx < 0));
  end

  // multiplier operand select
  always_comb begin
    unique case (state_q)
      P_X: begin
        mul_a = -33'(damping_q);
        mul_b = st_rdata_q;
      end
      P_M1: begin
        mul_a = 33'(gain_q);
        mul_b = cl;
      end
      P_DW: begin
        mul_a = 33'(coupling_q);
        mul_b = d_val;
      end
      default: begin
        mul_a = $signed({1'b0, time_step_q, 1'b0}) >>> 1;
        mul_b = rate_rdata_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    i_d     = i_q;
    k_d     = k_q;
    deg_d   = deg_q;
    x_d     = x_q;
    first_d = first_q;
    pos_d   = pos_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    sum_d   = sum_q;
    out_valid_d = out_valid_q && !out_take;
    rd_d    = rd_q;
    sync_d  = sync_q;
    bad_d   = bad_q;
    st_we   = 1'b0;
    st_waddr = i_idx;
    st_wdata = nx;
    st_raddr = i_idx;
    rate_we = 1'b0;
    deg_we  = 1'b0;
    deg_waddr = NODE_W'(node_i);
    deg_wdata = DEG_W'(value_i);
    nb_we   = 1'b0;
    nb_waddr = {NODE_W'(node_i), SLOT_W'(slot_i)};
    nb_wdata = NODE_W'(value_i);
    nb_raddr = {i_idx, SLOT_W'(k_q)};
    div_start = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        st_we     = 1'b1;
        st_waddr  = clr_q[TAB_AW-1 -: NODE_W];
        st_wdata  = '0;
        deg_we    = 1'b1;
        deg_waddr = clr_q[TAB_AW-1 -: NODE_W];
        deg_wdata = '0;
        nb_we     = 1'b1;
        nb_waddr  = clr_q;
        nb_wdata  = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        st_raddr = NODE_W'(node_i);
        st_waddr = NODE_W'(node_i);
        st_wdata = value_i;
        if (accept) begin
          rd_d   = '0;
          sync_d = SYNC_NONE;
          bad_d  = 1'b0;
          unique case (op_i)
            OP_WR_STATE: begin
              out_valid_d = 1'b1;
              bad_d = node_oob;
              st_we = !node_oob;
            end
            OP_WR_DEG: begin
              out_valid_d = 1'b1;
              bad_d = node_oob || value_i[31] || (value_i > $signed(32'(MAX_DEGREE)));
              deg_we = !bad_d;
            end
            OP_WR_NB: begin
              out_valid_d = 1'b1;
              bad_d = node_oob || ({29'd0, slot_i} >= 32'(MAX_DEGREE)) || value_i[31]
                      || (value_i >= $signed(32'(MAX_NODES)));
              nb_we = !bad_d;
            end
            OP_STEP: begin
              i_d     = '0;
              state_d = P_RD;
            end
            OP_RD_STATE: begin
              if (node_oob) begin
                out_valid_d = 1'b1;
                bad_d = 1'b1;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              bad_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_d = 1'b1;
        rd_d    = st_rdata_q;
        state_d = S_IDLE;
      end
      // rate pass: old states only
      P_RD: state_d = P_X;
      P_X: begin
        x_d     = st_rdata_q;
        deg_d   = deg_rdata_q;
        state_d = P_M1;
      end
      P_M1: begin
        acc_d   = prod_sh;
        state_d = P_M2;
      end
      P_M2: begin
        acc_d = acc_q + prod_sh;
        k_d   = '0;
        sum_d = '0;
        // no coupling for an isolated node
        state_d = (deg_q == '0) ? P_WR : P_NB;
      end
      P_NB: state_d = P_NA;
      P_NA: begin
        st_raddr = nb_rdata_q;
        state_d  = P_NS;
      end
      P_NS: begin
        sum_d = sum_q + SUM_W'(st_rdata_q);
        k_d   = k_q + 1'b1;
        state_d = (k_d == deg_q) ? P_DIV : P_NB;
      end
      P_DIV: begin
        div_start = 1'b1;
        state_d   = P_DW;
      end
      P_DW: begin
        if (div_st.done) state_d = P_M3;
      end
      P_M3: begin
        acc_d   = acc_q + prod_sh;
        state_d = P_WR;
      end
      P_WR: begin
        rate_we = 1'b1;
        if (last_node) begin
          i_d     = '0;
          pos_d   = 1'b0;
          neg_d   = 1'b0;
          state_d = Q_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = P_RD;
        end
      end
      // update pass: x += rate * dt
      Q_RD: state_d = Q_MUL;
      Q_MUL: begin
        x_d     = st_rdata_q;
        state_d = Q_ADD;
      end
      Q_ADD: begin
        st_we = 1'b1;
        if (i_q == '0) first_d = nx;
        pos_d = pos_f;
        neg_d = neg_f;
        if (last_node) begin
          out_valid_d = 1'b1;
          rd_d  = '0;
          bad_d = 1'b0;
          if (first_d > 0) sync_d = neg_f ? SYNC_NONE : SYNC_POS;
          else if (first_d < 0) sync_d = pos_f ? SYNC_NONE : SYNC_NEG;
          else sync_d = SYNC_NONE;
          state_d = S_IDLE;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = Q_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      i_q         <= i_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    deg_q   <= deg_d;
    x_q     <= x_d;
    first_q <= first_d;
    pos_q   <= pos_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
    rd_q    <= rd_d;
    sync_q  <= sync_d;
    bad_q   <= bad_d;
  end

  // config writes, index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= RST_NODE_COUNT;
      coupling_q   <= RST_COUPLING;
      time_step_q  <= RST_TIME_STEP;
      damping_q    <= RST_DAMPING;
      gain_q       <= RST_GAIN;
      upper_q      <= RST_UPPER_KNEE;
      lower_q      <= RST_LOWER_KNEE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT: node_count_q <= cfg_wdata_i[6:0];
        CFG_COUPLING:   coupling_q   <= cfg_wdata_i;
        CFG_TIME_STEP:  time_step_q  <= cfg_wdata_i[30:0];
        CFG_DAMPING:    damping_q    <= cfg_wdata_i;
        CFG_GAIN:       gain_q       <= cfg_wdata_i;
        CFG_UPPER_KNEE: upper_q      <= cfg_wdata_i;
        CFG_LOWER_KNEE: lower_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // memories, registered reads
  always_ff @(posedge clk_i) begin
    if (st_we) state_mem[st_waddr] <= st_wdata;
    st_rdata_q <= state_mem[st_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rate_we) rate_mem[i_idx] <= sat32(64'(acc_q));
    rate_rdata_q <= rate_mem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    deg_rdata_q <= deg_mem[i_idx];
  end

  always_ff @(posedge clk_i) begin
    if (nb_we) nb_mem[nb_waddr] <= nb_wdata;
    nb_rdata_q <= nb_mem[nb_raddr];
  end

  // neighbor mean divide
  bnes_div #(
    .NUM_W(SUM_W),
    .DEN_W(DEG_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (deg_q),
    .status_o(div_st),
    .quot_o  (quot)
  );

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = rd_q;
  assign sync_well_o   = sync_q;
  assign bad_request_o = bad_q;

  logic step_busy;
  assign step_busy = (state_q >= P_RD) && (state_q <= Q_ADD) && !first_f;

  `BNES_ASSERT(a_node_in_range, step_busy |-> (i_q < n_eff), "node counter past active count")
  `BNES_ASSERT(a_nb_in_range, (state_q == P_NS) |-> (k_q < deg_q), "neighbor slot past degree")
  `BNES_ASSERT(a_div_waited, div_st.done |-> (state_q == P_DW), "divide finished unawaited")
  `BNES_ASSERT(a_bad_clean, (out_valid_o && bad_request_o) |-> (read_value_o == 0 && sync_well_o == SYNC_NONE), "bad result carries data")
  `BNES_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks the euler step unit against a bit-exact predictor of the network:
// queued requests go through a clocked driver, a clocked monitor compares
// every result in order, phases vary the configuration and the idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import bnes_pkg::*;

  localparam int NODES      = 64;
  localparam int DEGREE_MAX = 8;
  localparam int CYCLE_CAP  = 3000000;
  localparam int DRAIN_WAIT = 40;
  localparam int LONG_HOLD  = 3000;
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]         op;
    logic [5:0]         node;
    logic [2:0]         slot;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         sync_well;
    logic               bad_request;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // request side
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         op_q = '0;
  logic [5:0]         node_q = '0;
  logic [2:0]         slot_q = '0;
  logic signed [31:0] value_q = '0;
  // result side
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value;
  logic [1:0]         sync_well;
  logic               bad_request;
  // config port
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_start = 1'b0;
  int       hold_left = 0;

  // shadow copy of the network
  logic signed [31:0] net_state [NODES];
  logic signed [31:0] net_rate  [NODES];
  logic [3:0]         net_degree[NODES];
  logic [5:0]         net_nb    [NODES*DEGREE_MAX];
  logic [6:0]         sh_count;
  longint             sh_coupling, sh_dt, sh_damping, sh_gain, sh_upper, sh_lower;

  bistable_network_euler_step_unit u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op_q),
    .node_i       (node_q),
    .slot_i       (slot_q),
    .value_i      (value_q),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_value_o (read_value),
    .sync_well_o  (sync_well),
    .bad_request_o(bad_request),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one euler step over the active nodes, returns the well code
  function automatic logic [1:0] euler_step();
    int     n;
    longint x, cl, rate, sum, d;
    n = int'(sh_count);
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    for (int i = 0; i < n; i++) begin
      x = longint'(net_state[i]);
      if (x < sh_lower) cl = sh_lower;
      else if (x <= sh_upper) cl = x;
      else cl = sh_upper;
      rate = ((-sh_damping * x) >>> FRAC) + ((sh_gain * cl) >>> FRAC);
      // zero degree: no coupling term
      if (net_degree[i] > 0) begin
        sum = 0;
        for (int k = 0; k < net_degree[i]; k++)
          sum += longint'(net_state[net_nb[i*DEGREE_MAX + k]]);
        d = sat_word(sum / longint'(net_degree[i]) - x);
        rate += (sh_coupling * d) >>> FRAC;
      end
      net_rate[i] = 32'(sat_word(rate));
    end
    for (int i = 0; i < n; i++)
      net_state[i] = 32'(sat_word(longint'(net_state[i]) +
                                  ((longint'(net_rate[i]) * sh_dt) >>> FRAC)));
    for (int i = 1; i < n; i++)
      if ((net_state[i] < 0 && net_state[0] > 0) || (net_state[i] > 0 && net_state[0] < 0))
        return SYNC_NONE;
    if (net_state[0] > 0) return SYNC_POS;
    if (net_state[0] < 0) return SYNC_NEG;
    return SYNC_NONE;
  endfunction

  function automatic result_t predict_result(request_t r);
    result_t res;
    res = '0;
    case (r.op)
      OP_WR_STATE: net_state[r.node] = r.value;
      OP_WR_DEG:
        if (r.value < 0 || r.value > DEGREE_MAX) res.bad_request = 1'b1;
        else net_degree[r.node] = r.value[3:0];
      OP_WR_NB:
        if (r.value < 0 || r.value >= NODES) res.bad_request = 1'b1;
        else net_nb[{r.node, r.slot}] = r.value[5:0];
      OP_STEP:     res.sync_well = euler_step();
      OP_RD_STATE: res.read_value = net_state[r.node];
      default:     res.bad_request = 1'b1;
    endcase
    return res;
  endfunction

  // driver: predict on acceptance, then offer the next queued request
  always @(posedge clk) begin
    logic taken;
    request_t nxt;
    taken = in_valid && !in_stall;
    if (taken) expected_results.push_back(predict_result({op_q, node_q, slot_q, value_q}));
    if (!in_valid || taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        in_valid <= 1'b1;
        op_q     <= nxt.op;
        node_q   <= nxt.node;
        slot_q   <= nxt.slot;
        value_q  <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_start) hold_left <= LONG_HOLD;
    else if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // monitor: compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (read_value !== want.read_value) begin
          $error("read_value expected %0d got %0d", want.read_value, read_value);
          error_count++;
        end
        if (sync_well !== want.sync_well) begin
          $error("sync_well expected %0d got %0d", want.sync_well, sync_well);
          error_count++;
        end
        if (bad_request !== want.bad_request) begin
          $error("bad_request expected %0d got %0d", want.bad_request, bad_request);
          error_count++;
        end
      end
    end
    out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_NODE_COUNT: sh_count    = data[6:0];
      CFG_COUPLING:   sh_coupling = longint'(signed'(data));
      CFG_TIME_STEP:  sh_dt       = longint'({1'b0, data[30:0]});
      CFG_DAMPING:    sh_damping  = longint'(signed'(data));
      CFG_GAIN:       sh_gain     = longint'(signed'(data));
      CFG_UPPER_KNEE: sh_upper    = longint'(signed'(data));
      CFG_LOWER_KNEE: sh_lower    = longint'(signed'(data));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_network(logic [31:0] cnt, logic [31:0] cpl, logic [31:0] dt,
                             logic [31:0] alp, logic [31:0] bet,
                             logic [31:0] xu, logic [31:0] xl);
    write_reg(CFG_NODE_COUNT, cnt);
    write_reg(CFG_COUPLING, cpl);
    write_reg(CFG_TIME_STEP, dt);
    write_reg(CFG_DAMPING, alp);
    write_reg(CFG_GAIN, bet);
    write_reg(CFG_UPPER_KNEE, xu);
    write_reg(CFG_LOWER_KNEE, xl);
  endtask

  // wait until nothing is queued, offered or outstanding
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_state();
    if ($urandom_range(3) == 0) return $urandom;
    // mostly within +-4.0 so the wells matter
    return int'($urandom_range(0, 134217728)) - 67108864;
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.node  = $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(sh_count > 8 ? 15 : 7));
    r.slot  = 3'($urandom);
    r.value = $urandom;
    if (pick < 28) begin
      r.op = OP_WR_STATE;
      r.value = rand_state();
    end else if (pick < 42) begin
      r.op = OP_WR_DEG;
      if ($urandom_range(9) != 0) r.value = $urandom_range(DEGREE_MAX);
    end else if (pick < 64) begin
      r.op = OP_WR_NB;
      if ($urandom_range(9) != 0) r.value = $urandom_range(sh_count > 8 ? 15 : 7);
    end else if (pick < 74) begin
      r.op = OP_STEP;
    end else if (pick < 95) begin
      r.op = OP_RD_STATE;
    end else begin
      r.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    end
    return r;
  endfunction

  task automatic random_phase(int items, int s_idle, int r_stall);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    repeat (items) pending_reqs.push_back(rand_request());
    drain();
  endtask

  initial begin
    for (int i = 0; i < NODES; i++) begin
      net_state[i]  = '0;
      net_rate[i]   = '0;
      net_degree[i] = '0;
    end
    foreach (net_nb[i]) net_nb[i] = '0;
    sh_count    = RST_NODE_COUNT;
    sh_coupling = RST_COUPLING;
    sh_dt       = RST_TIME_STEP;
    sh_damping  = RST_DAMPING;
    sh_gain     = RST_GAIN;
    sh_upper    = RST_UPPER_KNEE;
    sh_lower    = RST_LOWER_KNEE;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every op, each rejection, zero first state
    pending_reqs.push_back({OP_STEP, 6'd0, 3'd0, 32'sd0});                // all zero: unsync
    pending_reqs.push_back({OP_WR_STATE, 6'd0, 3'd0, 32'sh7fffffff});
    pending_reqs.push_back({OP_WR_STATE, 6'd63, 3'd7, 32'sh80000000});
    pending_reqs.push_back({OP_RD_STATE, 6'd0, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_RD_STATE, 6'd63, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_WR_DEG, 6'd1, 3'd0, 32'sd8});
    pending_reqs.push_back({OP_WR_DEG, 6'd2, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_WR_DEG, 6'd3, 3'd0, 32'sd9});              // degree too big
    pending_reqs.push_back({OP_WR_DEG, 6'd3, 3'd0, -32'sd1});             // negative degree
    pending_reqs.push_back({OP_WR_NB, 6'd1, 3'd7, 32'sd63});
    pending_reqs.push_back({OP_WR_NB, 6'd1, 3'd0, 32'sd64});              // neighbor out of range
    pending_reqs.push_back({OP_WR_NB, 6'd1, 3'd1, 32'sh80000000});
    pending_reqs.push_back({OP_UNUSED_LO, 6'd5, 3'd5, 32'sd5});
    pending_reqs.push_back({OP_UNUSED_HI, 6'd7, 3'd7, 32'shffffffff});
    pending_reqs.push_back({OP_STEP, 6'd0, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_RD_STATE, 6'd1, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_RD_STATE, 6'd63, 3'd0, 32'sd0});
    drain();

    // two nodes, first zero then negative, second positive; one unwritten neighbor beyond the count
    set_network(32'd2, 32'h0100_0000, 32'd167772, RST_DAMPING, RST_GAIN,
                RST_UPPER_KNEE, RST_LOWER_KNEE);
    pending_reqs.push_back({OP_WR_STATE, 6'd0, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_WR_STATE, 6'd1, 3'd0, 32'sd16777216});
    pending_reqs.push_back({OP_WR_NB, 6'd1, 3'd2, 32'sd40});
    pending_reqs.push_back({OP_WR_DEG, 6'd1, 3'd0, 32'sd3});
    pending_reqs.push_back({OP_STEP, 6'd0, 3'd0, 32'sd0});
    pending_reqs.push_back({OP_WR_STATE, 6'd0, 3'd0, -32'sd16777216});
    pending_reqs.push_back({OP_STEP, 6'd0, 3'd0, 32'sd0});
    drain();

    // no idling, count 0 acts as one node
    set_network(32'd0, $urandom, 32'h7fffffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h8000_0000);
    random_phase(100, 0, 0);

    set_network(32'd8, 32'h0080_0000, 32'd167772, RST_DAMPING, RST_GAIN,
                RST_UPPER_KNEE, RST_LOWER_KNEE);
    random_phase(220, 0, 0);

    // sender idles most cycles
    set_network(32'd5, $urandom, $urandom_range(0, 1 << 24), $urandom, $urandom,
                $urandom, $urandom);
    random_phase(200, 71, 0);

    // receiver stalls most cycles, with one long hold-off while requests pile up
    set_network(32'd3, 32'h0200_0000, 32'd0, RST_DAMPING, RST_GAIN, 32'h0,
                32'h0);
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    random_phase(200, 0, 71);

    // both sides idle, large network and count above the node range
    set_network(32'd127, 32'hff00_0000, 32'd1677721, RST_DAMPING, RST_GAIN,
                RST_UPPER_KNEE, RST_LOWER_KNEE);
    random_phase(140, 17, 17);
    set_network(32'd64, 32'h0040_0000, 32'd167772, 32'h0, 32'h0100_0000,
                RST_UPPER_KNEE, RST_LOWER_KNEE);
    random_phase(140, 17, 17);

    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/bnes_pkg.sv
hdl/bnes_div.sv
hdl/bistable_network_euler_step_unit.sv
sim/tb_top.sv
